>>> hw/rtl/tbtw_pkg.sv
// Shared types and constants for the Thumb branch target window checker.
package tbtw_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] RegBaseAddress = 2'd0;
  localparam logic [1:0] RegWindowLow   = 2'd1;
  localparam logic [1:0] RegWindowHigh  = 2'd2;

  // Register reset values
  localparam logic [31:0] BaseAddressRst = 32'h0000_20B4;
  localparam logic [31:0] WindowLowRst   = 32'h0001_3000;
  localparam logic [31:0] WindowHighRst  = 32'h0001_7000;

  // Opcode masks and patterns
  localparam logic [15:0] MaskOpcode   = 16'hF800;
  localparam logic [15:0] OpLongPrefix = 16'hF000;
  localparam logic [15:0] OpShort      = 16'hE000;
  localparam logic [15:0] MaskSuffix   = 16'hC000;

  // Pipeline offset: target is position plus four plus the decoded offset
  localparam logic [31:0] PcOffset = 32'd4;
  localparam logic [31:0] HalfwordStep = 32'd2;

  typedef enum logic [1:0] {
    KindNone  = 2'd0,
    KindLong  = 2'd1,
    KindShort = 2'd2
  } branch_kind_e;

  // One position waiting to be judged
  typedef struct packed {
    logic [15:0] halfword;
    logic [15:0] successor;
    logic [31:0] position;
    logic        final_pos;
  } job_t;

  // One judged position
  typedef struct packed {
    logic [31:0]  position;
    branch_kind_e kind;
    logic [31:0]  target;
    logic         in_window;
    logic         final_result;
  } result_t;

endpackage

>>> hw/rtl/tbtw_front.sv
// Scan state and two-entry job register fed by the input channel.
module tbtw_front import tbtw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_halfword_i,
  input  logic        is_last_i,
  input  logic [31:0] base_address_i,
  input  logic        pop_i,
  output logic        head_valid_o,
  output job_t        head_job_o
);

  logic [15:0] held_halfword_q, held_halfword_d;
  logic        held_valid_q, held_valid_d;
  logic [31:0] held_position_q, held_position_d;

  job_t slot0_q, slot0_d, slot1_q, slot1_d;
  logic slot0_v_q, slot0_v_d, slot1_v_q, slot1_v_d;

  logic        accept;
  logic [31:0] pos_new;
  job_t        job_a, job_b;

  // Job register is free once its last entry leaves this cycle
  assign in_ready_o   = !slot0_v_q || (pop_i && !slot1_v_q);
  assign accept       = in_valid_i && in_ready_o;
  assign head_valid_o = slot0_v_q;
  assign head_job_o   = slot0_q;

  assign pos_new = held_valid_q ? (held_position_q + HalfwordStep) : base_address_i;

  always_comb begin
    job_a.halfword  = held_halfword_q;
    job_a.successor = code_halfword_i;
    job_a.position  = held_position_q;
    job_a.final_pos = 1'b0;
    job_b.halfword  = code_halfword_i;
    job_b.successor = 16'h0000;
    job_b.position  = pos_new;
    job_b.final_pos = 1'b1;
  end

  always_comb begin
    held_halfword_d = held_halfword_q;
    held_valid_d    = held_valid_q;
    held_position_d = held_position_q;
    slot0_d   = slot0_q;
    slot1_d   = slot1_q;
    slot0_v_d = slot0_v_q;
    slot1_v_d = slot1_v_q;

    if (pop_i) begin
      if (slot1_v_q) begin
        slot0_d   = slot1_q;
        slot1_v_d = 1'b0;
      end else begin
        slot0_v_d = 1'b0;
      end
    end

    if (accept) begin
      if (is_last_i) begin
        held_valid_d    = 1'b0;
        held_halfword_d = 16'h0000;
        held_position_d = 32'h0000_0000;
      end else begin
        held_valid_d    = 1'b1;
        held_halfword_d = code_halfword_i;
        held_position_d = pos_new;
      end

      if (held_valid_q) begin
        slot0_d   = job_a;
        slot0_v_d = 1'b1;
        if (is_last_i) begin
          slot1_d   = job_b;
          slot1_v_d = 1'b1;
        end
      end else if (is_last_i) begin
        slot0_d   = job_b;
        slot0_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_halfword_q <= 16'h0000;
      held_valid_q    <= 1'b0;
      held_position_q <= 32'h0000_0000;
      slot0_v_q       <= 1'b0;
      slot1_v_q       <= 1'b0;
    end else begin
      held_halfword_q <= held_halfword_d;
      held_valid_q    <= held_valid_d;
      held_position_q <= held_position_d;
      slot0_v_q       <= slot0_v_d;
      slot1_v_q       <= slot1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

>>> hw/rtl/tbtw_judge.sv
// Branch decode, target add and window compare for one position.
module tbtw_judge import tbtw_pkg::*; (
  input  job_t        job_i,
  input  logic [31:0] window_low_i,
  input  logic [31:0] window_high_i,
  output result_t     result_o
);

  logic [15:0]  h, n;
  logic         s, i1, i2;
  logic         is_long, is_short;
  logic [31:0]  off_long, off_short, offset;
  logic [31:0]  target;
  branch_kind_e kind;

  assign h = job_i.halfword;
  assign n = job_i.successor;

  assign is_long  = ((h & MaskOpcode) == OpLongPrefix) && ((n & MaskSuffix) == MaskSuffix);
  assign is_short = (h & MaskOpcode) == OpShort;

  // I1/I2 are the inverted J bits xored with the sign
  assign s  = h[10];
  assign i1 = ~(n[13] ^ s);
  assign i2 = ~(n[11] ^ s);

  assign off_long  = {{7{s}}, s, i1, i2, h[9:0], n[10:0], 1'b0};
  assign off_short = {{20{h[10]}}, h[10:0], 1'b0};

  always_comb begin
    if (is_long) begin
      kind   = KindLong;
      offset = off_long;
    end else if (is_short) begin
      kind   = KindShort;
      offset = off_short;
    end else begin
      kind   = KindNone;
      offset = 32'h0000_0000;
    end
  end

  assign target = (kind == KindNone) ? 32'h0000_0000 : (job_i.position + offset + PcOffset);

  always_comb begin
    result_o.position     = job_i.position;
    result_o.kind         = kind;
    result_o.target       = target;
    result_o.in_window    = (kind != KindNone) && (target > window_low_i) &&
                            (target < window_high_i);
    result_o.final_result = job_i.final_pos;
  end

endmodule

>>> hw/rtl/thumb_branch_target_window_check.sv
// Top level: config registers, scan front end, judge and result register.
//
// Channel  | Dir | Handshake                  | Word
// ---------+-----+----------------------------+------------------------------------------
// in       | in  | in_valid_i / in_ready_o    | code_halfword_i, is_last_i
// out      | out | out_valid_o / out_ready_i  | position_address_o, branch_kind_o,
//          |     |                            | target_address_o, in_window_o,
//          |     |                            | final_result_o
// cfg      | in  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Each input word yields zero, one or two result words. Words are staged in a
// two-entry job register; the judge (decode, 32-bit add, two compares) sits
// between that register and the result register, so one result leaves per cycle
// while out_ready_i is high. A stream of one-result words then runs at one word
// per cycle; the last word of a scan yields two results (one if the scan held
// only that word) and holds off input while the second result waits.
// Reset clears the scan state, the job entries and the result valid; registers
// take their default values. A stall on out_ready_i backs up into in_ready_o
// only once the job register cannot drain. cfg_ready_o is always high.
module thumb_branch_target_window_check import tbtw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_halfword_i,
  input  logic        is_last_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] position_address_o,
  output logic [1:0]  branch_kind_o,
  output logic [31:0] target_address_o,
  output logic        in_window_o,
  output logic        final_result_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] base_address_q, window_low_q, window_high_q;

  logic    out_valid_q;
  result_t out_q;

  logic    head_valid, pop, out_free;
  job_t    head_job;
  result_t judged;

  // Register file; an unknown index is dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_address_q <= BaseAddressRst;
      window_low_q   <= WindowLowRst;
      window_high_q  <= WindowHighRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegBaseAddress: base_address_q <= cfg_data_i;
        RegWindowLow:   window_low_q   <= cfg_data_i;
        RegWindowHigh:  window_high_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Head job moves into the result register when that register is free
  assign out_free = !out_valid_q || out_ready_i;
  assign pop      = head_valid && out_free;

  tbtw_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .code_halfword_i,
    .is_last_i,
    .base_address_i (base_address_q),
    .pop_i          (pop),
    .head_valid_o   (head_valid),
    .head_job_o     (head_job)
  );

  tbtw_judge u_judge (
    .job_i         (head_job),
    .window_low_i  (window_low_q),
    .window_high_i (window_high_q),
    .result_o      (judged)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= head_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= judged;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign position_address_o = out_q.position;
  assign branch_kind_o      = out_q.kind;
  assign target_address_o   = out_q.target;
  assign in_window_o        = out_q.in_window;
  assign final_result_o     = out_q.final_result;

endmodule

>>> dv/testbench.sv
// Stimulus, prediction and checking for the Thumb branch target window checker.
module testbench import tbtw_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let the job and result registers empty out before a register
  // write or the end of the run.
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned WordsPerSegment = 67;
  localparam int unsigned SegmentsPerPhase = 4;
  // cfg_index_i is two bits wide, so index 3 exists on the port but maps to
  // no register: writes to it must be dropped.
  localparam logic [1:0] RegUnmapped = 2'd3;

  // One input word waiting to be driven
  typedef struct packed {
    logic [15:0] halfword;
    logic        last;
  } code_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] code_halfword_i = '0;
  logic        is_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] position_address_o;
  logic [1:0]  branch_kind_o;
  logic [31:0] target_address_o;
  logic        in_window_o;
  logic        final_result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  thumb_branch_target_window_check dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .code_halfword_i,
    .is_last_i,
    .out_valid_o,
    .out_ready_i,
    .position_address_o,
    .branch_kind_o,
    .target_address_o,
    .in_window_o,
    .final_result_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // Words queued by the stimulus process, and judged positions still owed by
  // the block, oldest first.
  code_word_t  pending_words[$];
  result_t     expected_results[$];

  // Handshake bookkeeping: the driver counts words it put on the bus, the
  // monitor counts words the block took. They differ only while a word waits.
  int unsigned words_sent = 0;
  int unsigned words_taken = 0;
  int unsigned mismatch_count = 0;

  // Idle rates in percent, changed per phase by the stimulus process
  int unsigned send_gap_pct = 0;
  int unsigned ready_stall_pct = 0;

  // Shadow copy of the configuration registers
  logic [31:0] scan_base = BaseAddressRst;
  logic [31:0] window_low = WindowLowRst;
  logic [31:0] window_high = WindowHighRst;

  // Shadow copy of the scan state: the halfword waiting for its successor
  logic [15:0] held_halfword = '0;
  logic        held_valid = 1'b0;
  logic [31:0] held_position = '0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // Judge one position: decode a long pair or a short branch, add the
  // pipeline offset and test the target against the open window.
  function automatic result_t judge_position(input logic [15:0] hw, input logic [15:0] succ,
                                             input logic [31:0] pos, input logic fin);
    result_t     r;
    logic [31:0] offset;
    logic        s;
    r = '0;
    r.position = pos;
    r.final_result = fin;
    r.kind = KindNone;
    offset = '0;
    s = hw[10];
    if ((hw & MaskOpcode) == OpLongPrefix && (succ & MaskSuffix) == MaskSuffix) begin
      // S:I1:I2:imm10:imm11:0, sign-extended from bit 24
      offset = {{8{s}}, ~(succ[13] ^ s), ~(succ[11] ^ s), hw[9:0], succ[10:0], 1'b0};
      r.kind = KindLong;
    end else if ((hw & MaskOpcode) == OpShort) begin
      offset = {{20{s}}, hw[10:0], 1'b0};
      r.kind = KindShort;
    end
    if (r.kind != KindNone) begin
      r.target = pos + offset + PcOffset;
      r.in_window = (r.target > window_low) && (r.target < window_high);
    end
    return r;
  endfunction

  // Advance the shadow scan by one accepted word and queue what it yields
  task automatic take_word(input logic [15:0] hw, input logic last);
    logic [31:0] pos;
    if (held_valid) begin
      expected_results.push_back(judge_position(held_halfword, hw, held_position, 1'b0));
      pos = held_position + HalfwordStep;
    end else begin
      // base address is sampled only when a scan starts
      pos = scan_base;
    end
    if (last) begin
      // final position of a scan sees a zero successor
      expected_results.push_back(judge_position(hw, 16'h0000, pos, 1'b1));
      held_valid = 1'b0;
      held_halfword = '0;
      held_position = '0;
    end else begin
      held_valid = 1'b1;
      held_halfword = hw;
      held_position = pos;
    end
  endtask

  // Driver: new word at the falling edge once the previous one was taken
  always @(negedge clk_i) begin : drive_words
    code_word_t w;
    if (!(in_valid_i && words_taken != words_sent)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        w = pending_words.pop_front();
        code_halfword_i <= w.halfword;
        is_last_i <= w.last;
        in_valid_i <= 1'b1;
        words_sent <= words_sent + 1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= ready_stall_pct);
  end

  // Monitor: everything is sampled at the rising edge
  always @(posedge clk_i) begin : watch_ports
    result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegBaseAddress: scan_base <= cfg_data_i;
          RegWindowLow:   window_low <= cfg_data_i;
          RegWindowHigh:  window_high <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        words_taken <= words_taken + 1;
        take_word(code_halfword_i, is_last_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected result word pos %h kind %0d target %h", $realtime,
                     position_address_o, branch_kind_o, target_address_o);
          end
        end else begin
          want = expected_results.pop_front();
          if (position_address_o !== want.position || branch_kind_o !== want.kind ||
              target_address_o !== want.target || in_window_o !== want.in_window ||
              final_result_o !== want.final_result) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: mismatch exp pos %h kind %0d target %h win %0b last %0b",
                       $realtime, want.position, want.kind, want.target, want.in_window,
                       want.final_result);
              $display("%0t:          got pos %h kind %0d target %h win %0b last %0b",
                       $realtime, position_address_o, branch_kind_o, target_address_o,
                       in_window_o, final_result_o);
            end
          end
        end
      end
    end
  end

  task automatic queue_word(input logic [15:0] hw, input logic last);
    code_word_t w;
    w.halfword = hw;
    w.last = last;
    pending_words.push_back(w);
  endtask

  // One register write; valid drops again afterwards
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Block is idle once every word went in and every result came out; a word
  // that yields nothing may still sit in the pipe, hence the extra cycles.
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Register settings between segments. A segment may end mid-scan, so a new
  // base must not move positions already held.
  task automatic apply_setting(input int unsigned sel);
    logic [31:0] base;
    base = $urandom();
    case (sel % 5)
      0: begin
        // window straddling the code so targets land on both sides
        write_reg(RegBaseAddress, base);
        write_reg(RegWindowLow, base - $urandom_range(32'h0100_0000));
        write_reg(RegWindowHigh, base + $urandom_range(32'h0100_0000));
      end
      1: begin
        // widest window
        write_reg(RegBaseAddress, 32'h0000_0000);
        write_reg(RegWindowLow, 32'h0000_0000);
        write_reg(RegWindowHigh, 32'hFFFF_FFFF);
      end
      2: begin
        // code near the top so positions and targets wrap; nothing fits
        write_reg(RegBaseAddress, 32'hFFFF_FFC0 | 32'($urandom_range(63)));
        write_reg(RegWindowLow, 32'hFFFF_FFFF);
        write_reg(RegWindowHigh, 32'h0000_0000);
        write_reg(RegUnmapped, $urandom());
      end
      3: begin
        // empty window, bounds equal
        write_reg(RegBaseAddress, base);
        write_reg(RegWindowLow, base);
        write_reg(RegWindowHigh, base);
        write_reg(RegUnmapped, $urandom());
      end
      default: begin
        // only the window moves; base stays
        write_reg(RegWindowLow, scan_base - 32'h0010_0000);
        write_reg(RegWindowHigh, 32'hFFFF_FFFF);
      end
    endcase
  endtask

  // Mostly pieces of well-formed code: long prefixes, suffixes, short branches
  function automatic logic [15:0] random_halfword();
    int unsigned pick;
    logic [15:0] r;
    pick = $urandom_range(99);
    r = 16'($urandom());
    if (pick < 30) begin
      return {5'b11110, r[10:0]};
    end else if (pick < 60) begin
      return {2'b11, r[13:0]};
    end else if (pick < 80) begin
      return {5'b11100, r[10:0]};
    end
    return r;
  endfunction

  initial begin
    int unsigned phase;
    int unsigned seg;
    int unsigned k;
    send_gap_pct = 10;
    ready_stall_pct = 68;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed scan with reset registers. F011/F800 is a long pair landing
    // inside the reset window; then short branches at both offset extremes,
    // long pairs at both offset extremes, a prefix without a suffix, and
    // all-zero and all-one words.
    queue_word(16'hF011, 1'b0);
    queue_word(16'hF800, 1'b0);
    queue_word(16'hE000, 1'b0);
    queue_word(16'hE7FF, 1'b0);
    queue_word(16'hE400, 1'b0);
    queue_word(16'hE3FF, 1'b0);
    queue_word(16'hF400, 1'b0);
    queue_word(16'hC000, 1'b0);
    queue_word(16'hF3FF, 1'b0);
    queue_word(16'hD7FF, 1'b0);
    queue_word(16'hF000, 1'b0);
    queue_word(16'h8000, 1'b0);
    queue_word(16'h0000, 1'b0);
    queue_word(16'hFFFF, 1'b1);
    // scan of a single word, then a long prefix that ends its scan
    queue_word(16'hE123, 1'b1);
    queue_word(16'hF7FF, 1'b1);
    wait_idle();

    // Directed wrap: positions roll over past the top of the address space
    write_reg(RegBaseAddress, 32'hFFFF_FFFC);
    write_reg(RegWindowLow, 32'hFFFF_FFF0);
    write_reg(RegWindowHigh, 32'h0000_0010);
    queue_word(16'hE000, 1'b0);
    queue_word(16'hE7FE, 1'b0);
    queue_word(16'hF7FF, 1'b0);
    queue_word(16'hFFFF, 1'b0);
    queue_word(16'hE7FF, 1'b1);
    wait_idle();

    // Random phases: receiver-heavy stalls, then sender-heavy, then none
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 10;
          ready_stall_pct = 68;
        end
        1: begin
          send_gap_pct = 68;
          ready_stall_pct = 10;
        end
        default: begin
          send_gap_pct = 0;
          ready_stall_pct = 0;
        end
      endcase
      for (seg = 0; seg < SegmentsPerPhase; seg++) begin
        apply_setting(phase * SegmentsPerPhase + seg);
        for (k = 0; k < WordsPerSegment; k++) begin
          queue_word(random_halfword(), $urandom_range(11) == 0);
        end
        wait_idle();
      end
    end

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/tbtw_pkg.sv
hw/rtl/tbtw_front.sv
hw/rtl/tbtw_judge.sv
hw/rtl/thumb_branch_target_window_check.sv
dv/testbench.sv
